FILE: src/assert_macros.svh
// assertion macros shared by the allocator rtl
// expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: src/ffpa_pkg.sv
// shared types, constants and codes of the first-fit pool allocator
// no dependencies
package ffpa_pkg;

    localparam int MAX_SMALL_POOLS  = 4;
    localparam int HEADERS_PER_POOL = 64;
    localparam int HEADER_BYTES     = 24;
    localparam int ALIGN_BYTES      = 16;
    localparam int POOL_TOTAL       = MAX_SMALL_POOLS + 1;
    localparam int BIG_POOL         = MAX_SMALL_POOLS;
    localparam int ARENA_MAX        = 1048576;

    localparam int POOL_W    = 3;
    localparam int OFF_W     = 20;
    localparam int SIZE_W    = 21;
    localparam int ASZ_W     = 22;
    localparam int USED_W    = 23;
    localparam int IDX_W     = $clog2(HEADERS_PER_POOL);
    localparam int CNT_W     = $clog2(HEADERS_PER_POOL + 1);
    localparam int ADDR_W    = POOL_W + IDX_W;
    localparam int MEM_DEPTH = POOL_TOTAL * (1 << IDX_W);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_W      = 21;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SMALL_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SMALL_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SMALL_BYTES = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LARGE_BYTES = 2'd3;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_NOT_BUSY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_LAYOUT,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_RE_CHK,
        S_ALLOC,
        S_TAKE_RD,
        S_TAKE_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_MARK_WR,
        S_REL_RD,
        S_REL_CHK,
        S_REL_LAST,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] size;
        logic              busy;
    } t_hdr;

    typedef struct packed {
        t_alu_op          op;
        logic [ASZ_W-1:0] a;
        logic [ASZ_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ASZ_W-1:0] y;
        logic             ge;
    } t_alu_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_hdr              data;
    } t_mem_wr;

endpackage

FILE: src/ffpa_hdr_mem.sv
// header table memory, one write and one registered read port
// depends on ffpa_pkg
module ffpa_hdr_mem (
    input  logic                       i_clk,
    input  ffpa_pkg::t_mem_wr          i_wr,
    input  logic [ffpa_pkg::ADDR_W-1:0] i_raddr,
    output ffpa_pkg::t_hdr             o_rdata
);

    ffpa_pkg::t_hdr r_mem [ffpa_pkg::MEM_DEPTH];
    ffpa_pkg::t_hdr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ffpa_alu.sv
// shared add / subtract-compare unit of the allocator sequencer
// depends on ffpa_pkg
module ffpa_alu (
    input  ffpa_pkg::t_alu_req i_req,
    output ffpa_pkg::t_alu_rsp o_rsp
);

    logic [ffpa_pkg::ASZ_W:0] w_sum;

    always_comb begin
        if (i_req.op == ffpa_pkg::ALU_SUB) begin
            w_sum = {1'b0, i_req.a} + {1'b0, ~i_req.b} + (ffpa_pkg::ASZ_W + 1)'(1);
        end else begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    // carry out of a subtract means a >= b
    assign o_rsp.y  = w_sum[ffpa_pkg::ASZ_W-1:0];
    assign o_rsp.ge = w_sum[ffpa_pkg::ASZ_W];

endmodule

FILE: src/first_fit_pool_allocator.sv
// first-fit pool allocator top: sequencer, pool state, config and output register
// depends on ffpa_pkg, ffpa_hdr_mem, ffpa_alu, assert_macros.svh
//
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tdata: req_size, pool_number, data_offset
//                                      tuser: opcode, has_block
// m_axis   out  tvalid/tready          tdata: got_pool, got_offset, copy_bytes, used_total
//                                      tuser: status, got_valid
// cfg      in   i_cfg_we               i_cfg_addr, i_cfg_data
//
// one item at a time; header scans read each entry from the table memory, then check it
// alloc: scans the headers over the pools tried; a split moves later entries up one slot
// free: a header scan finds the block, then a merge sweep runs over the pool's entries
// reset and geometry writes lay out every pool in turn, s_axis_tready low meanwhile
// a finished item waits in the output register; the next item is taken meanwhile
`include "assert_macros.svh"

module first_fit_pool_allocator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ffpa_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ffpa_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // req_size[20:0], pool_number[23:21], data_offset[43:24]
    input  logic [ffpa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode[1:0], has_block[2]
    input  logic [ffpa_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // got_pool[2:0], got_offset[22:3], copy_bytes[43:23], used_total[66:44]
    output logic [ffpa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status[1:0], got_valid[2]
    output logic [ffpa_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    ffpa_pkg::t_state r_state, n_state;

    logic [ffpa_pkg::SIZE_W-1:0] r_limit, r_spb, r_lpb;
    logic [ffpa_pkg::POOL_W-1:0] r_spc;

    logic [ffpa_pkg::CNT_W-1:0]  r_cnt [ffpa_pkg::POOL_TOTAL];
    logic [ffpa_pkg::USED_W-1:0] r_used;
    logic [ffpa_pkg::POOL_W-1:0] r_lay;

    logic [ffpa_pkg::SIZE_W-1:0] r_req;
    logic [ffpa_pkg::ASZ_W-1:0]  r_asz;
    logic [ffpa_pkg::POOL_W-1:0] r_pn, r_pool;
    logic [ffpa_pkg::OFF_W-1:0]  r_off;
    logic                        r_free, r_realloc;
    logic [ffpa_pkg::CNT_W-1:0]  r_idx, r_k, r_j, r_w;
    logic [ffpa_pkg::SIZE_W-1:0] r_old;
    ffpa_pkg::t_hdr              r_hit, r_new, r_acc;

    ffpa_pkg::t_status           r_status;
    logic                        r_gvalid;
    logic [ffpa_pkg::POOL_W-1:0] r_gpool;
    logic [ffpa_pkg::OFF_W-1:0]  r_goff;
    logic [ffpa_pkg::SIZE_W-1:0] r_copy;

    logic                        r_mv;
    ffpa_pkg::t_status           r_m_status;
    logic                        r_m_gvalid;
    logic [ffpa_pkg::POOL_W-1:0] r_m_gpool;
    logic [ffpa_pkg::OFF_W-1:0]  r_m_goff;
    logic [ffpa_pkg::SIZE_W-1:0] r_m_copy;
    logic [ffpa_pkg::USED_W-1:0] r_m_used;

    ffpa_pkg::t_mem_wr           w_wr;
    logic [ffpa_pkg::ADDR_W-1:0] w_raddr;
    ffpa_pkg::t_hdr              w_rd;
    ffpa_pkg::t_alu_req          w_alu_req;
    ffpa_pkg::t_alu_rsp          w_alu;

    ffpa_hdr_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    ffpa_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu)
    );

    // input unpack
    logic [ffpa_pkg::SIZE_W-1:0] w_in_req;
    logic [ffpa_pkg::POOL_W-1:0] w_in_pn;
    logic [ffpa_pkg::OFF_W-1:0]  w_in_off;
    ffpa_pkg::t_op               w_in_op;
    logic                        w_in_has;

    assign w_in_req = s_axis_tdata[20:0];
    assign w_in_pn  = s_axis_tdata[23:21];
    assign w_in_off = s_axis_tdata[43:24];
    assign w_in_op  = ffpa_pkg::t_op'(s_axis_tuser[1:0]);
    assign w_in_has = s_axis_tuser[2];

    // pool geometry
    logic [ffpa_pkg::POOL_W-1:0] w_active;
    logic [ffpa_pkg::SIZE_W-1:0] w_spb_sat, w_lpb_sat, w_lay_arena, w_pn_arena;
    logic                        w_lay_live, w_loc_bad;

    assign w_active  = (r_spc > ffpa_pkg::POOL_W'(ffpa_pkg::MAX_SMALL_POOLS))
                       ? ffpa_pkg::POOL_W'(ffpa_pkg::MAX_SMALL_POOLS) : r_spc;
    assign w_spb_sat = (r_spb > ffpa_pkg::SIZE_W'(ffpa_pkg::ARENA_MAX))
                       ? ffpa_pkg::SIZE_W'(ffpa_pkg::ARENA_MAX) : r_spb;
    assign w_lpb_sat = (r_lpb > ffpa_pkg::SIZE_W'(ffpa_pkg::ARENA_MAX))
                       ? ffpa_pkg::SIZE_W'(ffpa_pkg::ARENA_MAX) : r_lpb;

    assign w_lay_arena = (r_lay == ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) ? w_lpb_sat : w_spb_sat;
    assign w_lay_live  = ((r_lay == ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) || (r_lay < w_active))
                         && (w_lay_arena >= ffpa_pkg::SIZE_W'(ffpa_pkg::HEADER_BYTES));

    assign w_pn_arena = (w_in_pn == ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) ? w_lpb_sat : w_spb_sat;
    assign w_loc_bad  = (w_in_pn > ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL))
                        || ((w_in_pn < ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) && (w_in_pn >= w_active))
                        || ({1'b0, w_in_off} >= w_pn_arena);

    // request decode
    logic w_is_alloc, w_is_free, w_is_re;

    assign w_is_alloc = (w_in_op == ffpa_pkg::OP_ALLOC) || ((w_in_op == ffpa_pkg::OP_REALLOC) && !w_in_has);
    assign w_is_free  = !w_is_alloc && ((w_in_op == ffpa_pkg::OP_FREE)
                        || ((w_in_op == ffpa_pkg::OP_REALLOC) && (w_in_req == '0)));
    assign w_is_re    = !w_is_alloc && !w_is_free && (w_in_op == ffpa_pkg::OP_REALLOC);

    logic [ffpa_pkg::ASZ_W-1:0] w_asz_sum, w_in_asz;

    assign w_asz_sum = {1'b0, w_in_req} + ffpa_pkg::ASZ_W'(ffpa_pkg::ALIGN_BYTES - 1);
    assign w_in_asz  = w_asz_sum & ~ffpa_pkg::ASZ_W'(ffpa_pkg::ALIGN_BYTES - 1);

    // scan helpers
    logic [ffpa_pkg::CNT_W-1:0]  w_cnt_pool, w_cnt_pn;
    logic [ffpa_pkg::POOL_W-1:0] w_next_small;
    logic                        w_small_first, w_find_hit, w_fit, w_split, w_shift_first;
    logic                        w_shift_more, w_rel_match, w_merge;
    ffpa_pkg::t_hdr              w_rel_e;
    logic [ffpa_pkg::SIZE_W-1:0] w_rd_end;

    assign w_cnt_pool    = r_cnt[r_pool];
    assign w_cnt_pn      = r_cnt[r_pn];
    assign w_next_small  = r_pool + 1'b1;
    assign w_small_first = (r_asz <= {1'b0, r_limit}) && (w_active != '0);
    assign w_find_hit    = w_rd.busy && (w_alu.y == ffpa_pkg::ASZ_W'(r_off));
    assign w_fit         = !w_rd.busy && w_alu.ge;
    assign w_split       = (w_alu.y >= ffpa_pkg::ASZ_W'(ffpa_pkg::HEADER_BYTES))
                           && (w_cnt_pool < ffpa_pkg::CNT_W'(ffpa_pkg::HEADERS_PER_POOL));
    assign w_shift_first = {1'b0, w_cnt_pool} > ({1'b0, r_idx} + (ffpa_pkg::CNT_W + 1)'(1));
    assign w_shift_more  = {1'b0, r_k} > ({1'b0, r_idx} + (ffpa_pkg::CNT_W + 1)'(2));
    assign w_rd_end      = {1'b0, w_rd.start} + ffpa_pkg::SIZE_W'(ffpa_pkg::HEADER_BYTES);
    assign w_rel_match   = w_rd.busy && (w_rd_end == {1'b0, r_off});

    always_comb begin
        w_rel_e = w_rd;
        if (w_rel_match) begin
            w_rel_e.busy = 1'b0;
        end
    end

    assign w_merge = !r_acc.busy && !w_rel_e.busy;

    logic w_load;
    assign w_load = (r_state == ffpa_pkg::S_DONE) && (!r_mv || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffpa_pkg::S_LAYOUT: begin
                if (r_lay == ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) n_state = ffpa_pkg::S_IDLE;
            end
            ffpa_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (w_is_alloc) begin
                        n_state = ffpa_pkg::S_ALLOC;
                    end else if ((w_is_free && w_in_has && !w_loc_bad) || (w_is_re && !w_loc_bad)) begin
                        n_state = ffpa_pkg::S_FIND_RD;
                    end else begin
                        n_state = ffpa_pkg::S_DONE;
                    end
                end
            end
            ffpa_pkg::S_FIND_RD: begin
                n_state = (r_idx >= w_cnt_pn) ? ffpa_pkg::S_DONE : ffpa_pkg::S_FIND_CHK;
            end
            ffpa_pkg::S_FIND_CHK: begin
                if (w_find_hit) begin
                    n_state = r_free ? ffpa_pkg::S_REL_RD : ffpa_pkg::S_RE_CHK;
                end else begin
                    n_state = ffpa_pkg::S_FIND_RD;
                end
            end
            ffpa_pkg::S_RE_CHK: begin
                n_state = w_alu.ge ? ffpa_pkg::S_DONE : ffpa_pkg::S_ALLOC;
            end
            ffpa_pkg::S_ALLOC: n_state = ffpa_pkg::S_TAKE_RD;
            ffpa_pkg::S_TAKE_RD: begin
                if (r_idx < w_cnt_pool) begin
                    n_state = ffpa_pkg::S_TAKE_CHK;
                end else if (r_pool == ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) begin
                    n_state = ffpa_pkg::S_DONE;
                end
            end
            ffpa_pkg::S_TAKE_CHK: begin
                if (!w_fit) begin
                    n_state = ffpa_pkg::S_TAKE_RD;
                end else if (!w_split) begin
                    n_state = ffpa_pkg::S_MARK_WR;
                end else begin
                    n_state = w_shift_first ? ffpa_pkg::S_SHIFT_RD : ffpa_pkg::S_SPLIT_WR;
                end
            end
            ffpa_pkg::S_SHIFT_RD: n_state = ffpa_pkg::S_SHIFT_WR;
            ffpa_pkg::S_SHIFT_WR: begin
                n_state = w_shift_more ? ffpa_pkg::S_SHIFT_RD : ffpa_pkg::S_SPLIT_WR;
            end
            ffpa_pkg::S_SPLIT_WR: n_state = ffpa_pkg::S_MARK_WR;
            ffpa_pkg::S_MARK_WR: begin
                n_state = r_realloc ? ffpa_pkg::S_REL_RD : ffpa_pkg::S_DONE;
            end
            ffpa_pkg::S_REL_RD: begin
                n_state = (r_j >= w_cnt_pn) ? ffpa_pkg::S_REL_LAST : ffpa_pkg::S_REL_CHK;
            end
            ffpa_pkg::S_REL_CHK: n_state = ffpa_pkg::S_REL_RD;
            ffpa_pkg::S_REL_LAST: n_state = ffpa_pkg::S_DONE;
            ffpa_pkg::S_DONE: begin
                if (w_load) n_state = ffpa_pkg::S_IDLE;
            end
            default: n_state = ffpa_pkg::S_IDLE;
        endcase
        if (i_cfg_we && (i_cfg_addr != ffpa_pkg::CFG_SMALL_LIMIT)) begin
            n_state = ffpa_pkg::S_LAYOUT;
        end
    end

    // memory, alu and handshake controls
    always_comb begin
        s_axis_tready  = (r_state == ffpa_pkg::S_IDLE);
        w_wr           = '0;
        w_raddr        = '0;
        w_alu_req.op   = ffpa_pkg::ALU_ADD;
        w_alu_req.a    = '0;
        w_alu_req.b    = '0;
        case (r_state)
            ffpa_pkg::S_LAYOUT: begin
                w_wr.we         = 1'b1;
                w_wr.addr       = {r_lay, {ffpa_pkg::IDX_W{1'b0}}};
                w_wr.data.start = '0;
                w_wr.data.size  = w_lay_arena - ffpa_pkg::SIZE_W'(ffpa_pkg::HEADER_BYTES);
                w_wr.data.busy  = 1'b0;
            end
            ffpa_pkg::S_FIND_RD: w_raddr = {r_pn, r_idx[ffpa_pkg::IDX_W-1:0]};
            ffpa_pkg::S_FIND_CHK: begin
                w_alu_req.a = ffpa_pkg::ASZ_W'(w_rd.start);
                w_alu_req.b = ffpa_pkg::ASZ_W'(ffpa_pkg::HEADER_BYTES);
            end
            ffpa_pkg::S_RE_CHK: begin
                w_alu_req.op = ffpa_pkg::ALU_SUB;
                w_alu_req.a  = ffpa_pkg::ASZ_W'(r_old);
                w_alu_req.b  = ffpa_pkg::ASZ_W'(r_req);
            end
            ffpa_pkg::S_TAKE_RD: w_raddr = {r_pool, r_idx[ffpa_pkg::IDX_W-1:0]};
            ffpa_pkg::S_TAKE_CHK: begin
                w_alu_req.op = ffpa_pkg::ALU_SUB;
                w_alu_req.a  = ffpa_pkg::ASZ_W'(w_rd.size);
                w_alu_req.b  = r_asz;
            end
            ffpa_pkg::S_SHIFT_RD: begin
                w_raddr = {r_pool, r_k[ffpa_pkg::IDX_W-1:0] - 1'b1};
            end
            ffpa_pkg::S_SHIFT_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = {r_pool, r_k[ffpa_pkg::IDX_W-1:0]};
                w_wr.data = w_rd;
            end
            ffpa_pkg::S_SPLIT_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = {r_pool, r_idx[ffpa_pkg::IDX_W-1:0] + 1'b1};
                w_wr.data = r_new;
            end
            ffpa_pkg::S_MARK_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = {r_pool, r_idx[ffpa_pkg::IDX_W-1:0]};
                w_wr.data = r_hit;
            end
            ffpa_pkg::S_REL_RD: w_raddr = {r_pn, r_j[ffpa_pkg::IDX_W-1:0]};
            ffpa_pkg::S_REL_CHK: begin
                w_alu_req.a = ffpa_pkg::ASZ_W'(r_acc.size);
                w_alu_req.b = ffpa_pkg::ASZ_W'(w_rel_e.size) + ffpa_pkg::ASZ_W'(ffpa_pkg::HEADER_BYTES);
                if ((r_j != '0) && !w_merge) begin
                    w_wr.we   = 1'b1;
                    w_wr.addr = {r_pn, r_w[ffpa_pkg::IDX_W-1:0]};
                    w_wr.data = r_acc;
                end
            end
            ffpa_pkg::S_REL_LAST: begin
                w_wr.we   = 1'b1;
                w_wr.addr = {r_pn, r_w[ffpa_pkg::IDX_W-1:0]};
                w_wr.data = r_acc;
            end
            default: begin
            end
        endcase
    end

    // control and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::S_LAYOUT;
            r_lay   <= '0;
            r_limit <= ffpa_pkg::SIZE_W'(256);
            r_spc   <= ffpa_pkg::POOL_W'(4);
            r_spb   <= ffpa_pkg::SIZE_W'(65536);
            r_lpb   <= ffpa_pkg::SIZE_W'(1048576);
            r_used  <= '0;
            r_mv    <= 1'b0;
            for (int p = 0; p < ffpa_pkg::POOL_TOTAL; p++) begin
                r_cnt[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ffpa_pkg::CFG_SMALL_LIMIT: r_limit <= i_cfg_data;
                    ffpa_pkg::CFG_SMALL_COUNT: r_spc   <= i_cfg_data[ffpa_pkg::POOL_W-1:0];
                    ffpa_pkg::CFG_SMALL_BYTES: r_spb   <= i_cfg_data;
                    ffpa_pkg::CFG_LARGE_BYTES: r_lpb   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cfg_we && (i_cfg_addr != ffpa_pkg::CFG_SMALL_LIMIT)) begin
                r_lay <= '0;
            end else if (r_state == ffpa_pkg::S_LAYOUT) begin
                r_lay        <= r_lay + 1'b1;
                r_cnt[r_lay] <= w_lay_live ? ffpa_pkg::CNT_W'(1) : '0;
                r_used       <= '0;
            end

            if ((r_state == ffpa_pkg::S_SPLIT_WR)) begin
                r_cnt[r_pool] <= w_cnt_pool + 1'b1;
            end
            if (r_state == ffpa_pkg::S_MARK_WR) begin
                r_used <= r_used + ffpa_pkg::USED_W'(r_hit.size)
                          + ffpa_pkg::USED_W'(ffpa_pkg::HEADER_BYTES);
            end
            if ((r_state == ffpa_pkg::S_REL_CHK) && w_rel_match) begin
                r_used <= r_used - ffpa_pkg::USED_W'(w_rd.size)
                          - ffpa_pkg::USED_W'(ffpa_pkg::HEADER_BYTES);
            end
            if (r_state == ffpa_pkg::S_REL_LAST) begin
                r_cnt[r_pn] <= r_w + 1'b1;
            end

            if (w_load) begin
                r_mv <= 1'b1;
            end else if (m_axis_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ffpa_pkg::S_IDLE: begin
                r_req     <= w_in_req;
                r_asz     <= w_in_asz;
                r_pn      <= w_in_pn;
                r_off     <= w_in_off;
                r_free    <= w_is_free;
                r_realloc <= 1'b0;
                r_idx     <= '0;
                r_gvalid  <= 1'b0;
                r_gpool   <= '0;
                r_goff    <= '0;
                r_copy    <= '0;
                r_status  <= ((w_is_free && w_in_has) || w_is_re) && w_loc_bad
                             ? ffpa_pkg::ST_OUTSIDE : ffpa_pkg::ST_OK;
            end
            ffpa_pkg::S_FIND_RD: begin
                if (r_idx >= w_cnt_pn) r_status <= ffpa_pkg::ST_NOT_BUSY;
            end
            ffpa_pkg::S_FIND_CHK: begin
                r_idx <= r_idx + 1'b1;
                r_old <= w_rd.size;
                r_j   <= '0;
                r_w   <= '0;
            end
            ffpa_pkg::S_RE_CHK: begin
                if (w_alu.ge) begin
                    r_gvalid <= 1'b1;
                    r_gpool  <= r_pn;
                    r_goff   <= r_off;
                end
                r_realloc <= 1'b1;
            end
            ffpa_pkg::S_ALLOC: begin
                r_pool <= w_small_first ? '0 : ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL);
                r_idx  <= '0;
            end
            ffpa_pkg::S_TAKE_RD: begin
                if (r_idx >= w_cnt_pool) begin
                    r_idx <= '0;
                    if (r_pool == ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL)) begin
                        r_status <= ffpa_pkg::ST_NO_FIT;
                    end else if (w_next_small < w_active) begin
                        r_pool <= w_next_small;
                    end else begin
                        r_pool <= ffpa_pkg::POOL_W'(ffpa_pkg::BIG_POOL);
                    end
                end
            end
            ffpa_pkg::S_TAKE_CHK: begin
                if (w_fit) begin
                    r_hit.start <= w_rd.start;
                    r_hit.size  <= w_split ? ffpa_pkg::SIZE_W'(r_asz) : w_rd.size;
                    r_hit.busy  <= 1'b1;
                    r_new.start <= w_rd.start + ffpa_pkg::OFF_W'(ffpa_pkg::HEADER_BYTES)
                                   + ffpa_pkg::OFF_W'(r_asz);
                    r_new.size  <= ffpa_pkg::SIZE_W'(w_alu.y - ffpa_pkg::ASZ_W'(ffpa_pkg::HEADER_BYTES));
                    r_new.busy  <= 1'b0;
                    r_k         <= w_cnt_pool;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            ffpa_pkg::S_SHIFT_WR: r_k <= r_k - 1'b1;
            ffpa_pkg::S_MARK_WR: begin
                r_gvalid <= 1'b1;
                r_gpool  <= r_pool;
                r_goff   <= r_hit.start + ffpa_pkg::OFF_W'(ffpa_pkg::HEADER_BYTES);
                r_copy   <= r_realloc ? r_old : '0;
                r_j      <= '0;
                r_w      <= '0;
            end
            ffpa_pkg::S_REL_CHK: begin
                r_j <= r_j + 1'b1;
                if (r_j == '0) begin
                    r_acc <= w_rel_e;
                end else if (w_merge) begin
                    r_acc.size <= w_alu.y[ffpa_pkg::SIZE_W-1:0];
                end else begin
                    r_acc <= w_rel_e;
                    r_w   <= r_w + 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_load) begin
            r_m_status <= r_status;
            r_m_gvalid <= r_gvalid;
            r_m_gpool  <= r_gpool;
            r_m_goff   <= r_goff;
            r_m_copy   <= r_copy;
            r_m_used   <= r_used;
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {5'b0, r_m_used, r_m_copy, r_m_goff, r_m_gpool};
    assign m_axis_tuser  = {r_m_gvalid, r_m_status};

    `ASSERT_CLK(a_cnt_large, r_cnt[ffpa_pkg::BIG_POOL] <= ffpa_pkg::CNT_W'(ffpa_pkg::HEADERS_PER_POOL), "large pool header count overflow")
    `ASSERT_CLK(a_cnt_first, r_cnt[0] <= ffpa_pkg::CNT_W'(ffpa_pkg::HEADERS_PER_POOL), "small pool header count overflow")
    `ASSERT_CLK(a_valid_ok, r_mv && r_m_gvalid |-> r_m_status == ffpa_pkg::ST_OK, "block returned with error status")
    `ASSERT_CLK(a_idle_no_write, r_state == ffpa_pkg::S_IDLE |-> !w_wr.we, "table written while idle")
    `ASSERT_CLK(a_out_from_done, $rose(r_mv) |-> $past(r_state == ffpa_pkg::S_DONE), "output loaded outside done")

endmodule
